FILE: sv/ls3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ls3_pkg: shared types, constants and helpers for the 3x3 solver
// Q16.16 arithmetic helpers and the queue entry type.
// ---------------------------------------------------------------------------
package ls3_pkg;
   localparam int DW = 32;
   localparam int FB = 16;

   typedef logic signed [DW-1:0] word_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SING = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      word_type [2:0][3:0] m;
   } job_type;

   localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   function automatic logic [DW:0] mag(input word_type v);
      logic [DW:0] r;
      r = v[DW-1] ? (~{1'b1, v} + 1'b1) : {1'b0, v};
      return r;
   endfunction

   // Saturating subtract; flag in bit DW.
   function automatic logic [DW:0] fsub(input word_type a, input word_type b);
      logic signed [DW:0] d;
      logic [DW:0] r;
      d = {a[DW-1], a} - {b[DW-1], b};
      if (d > $signed({2'b00, MAXV[DW-2:0]})) r = {1'b1, MAXV};
      else if (d < $signed({1'b1, MINV})) r = {1'b1, MINV};
      else r = {1'b0, d[DW-1:0]};
      return r;
   endfunction

   function automatic logic [DW:0] pack(input logic [2*DW+1:0] q, input logic neg);
      logic [DW:0] r;
      logic [2*DW+1:0] lim;
      lim = neg ? (2*DW+2)'({1'b1, {(DW-1){1'b0}}}) : (2*DW+2)'(MAXV);
      if (q > lim) r = {1'b1, neg ? MINV : MAXV};
      else r = {1'b0, neg ? DW'(~q[DW-1:0] + 1'b1) : q[DW-1:0]};
      return r;
   endfunction

   // Rounded Q product; flag in bit DW.
   function automatic logic [DW:0] fmul(input word_type a, input word_type b);
      logic [DW:0] ma, mb;
      logic [2*DW+1:0] p;
      logic [2*DW+1:0] q;
      logic neg;
      logic [DW:0] r;
      ma = mag(a);
      mb = mag(b);
      neg = a[DW-1] ^ b[DW-1];
      p = ma * mb;
      q = (p + (2*DW+2)'(1 << (FB-1))) >> FB;
      r = pack(q, neg);
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: sv/ls3_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ls3_div: iterative Q16.16 divider
// Restoring division, one quotient bit per cycle, rounded and saturated.
// ---------------------------------------------------------------------------
module ls3_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ls3_pkg::word_type num,
   input  wire ls3_pkg::word_type den,
   output logic                   done,
   output ls3_pkg::word_type      quo,
   output logic                   sat
);
   import ls3_pkg::*;
   localparam int NW = DW + 1 + FB;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] n_ff, n_in;
   logic [DW+1:0] rem_ff, rem_in;
   logic [DW:0]   d_ff, d_in;
   logic [2*DW+1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, zero_ff, zero_in, nz_ff, nz_in;
   logic          done_ff, done_in;
   logic [DW+1:0] trial;
   logic [2*DW+1:0] qr;
   logic [DW:0]   pk;

   always_comb begin
      n_in = n_ff; rem_in = rem_ff; d_in = d_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff; nz_in = nz_ff;
      done_in = 1'b0;
      trial = {rem_ff[DW:0], n_ff[NW-1]};
      if (start) begin
         n_in = NW'(mag(num)) << FB;
         d_in = mag(den);
         rem_in = '0; q_in = '0; cnt_in = CW'(NW);
         busy_in = 1'b1;
         neg_in = num[DW-1] ^ den[DW-1];
         zero_in = (den == '0);
         nz_in = (num != '0);
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in = {q_ff[2*DW:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[2*DW:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff <= n_in; rem_ff <= rem_in; d_ff <= d_in; q_ff <= q_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; zero_ff <= zero_in; nz_ff <= nz_in;
   end

   // Round half away from zero: remainder at least half the divisor.
   always_comb begin
      qr = q_ff + ((rem_ff >= ({1'b0, d_ff} - rem_ff)) ? 1'b1 : 1'b0);
      pk = pack(qr, neg_ff);
      if (zero_ff) begin
         sat = 1'b1;
         // With a zero divisor the sign flag is the sign of the dividend.
         quo = !nz_ff ? '0 : (neg_ff ? MINV : MAXV);
      end else begin
         sat = pk[DW];
         quo = pk[DW-1:0];
      end
   end
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: sv/ls3_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ls3_front: input capture and two-entry queue
// Registers accepted systems into a small FIFO toward the solver core.
// ---------------------------------------------------------------------------
module ls3_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ls3_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  avail,
   output ls3_pkg::job_type      head
);
   import ls3_pkg::*;
   job_type q_ff [2];
   logic    wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) q_ff[wp_ff] <= push_job;
   end
   assign full = cnt_ff == 2'd2;
   assign avail = cnt_ff != 2'd0;
   assign head = q_ff[rp_ff];
endmodule
`default_nettype wire

FILE: sv/ls3_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ls3_core: elimination and back-substitution sequencer
// Steps through pivot, divide, update and back-substitution one op per cycle, holding while the divider works.
// ---------------------------------------------------------------------------
module ls3_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [30:0]      thresh,
   input  wire logic             avail,
   input  wire ls3_pkg::job_type job,
   output logic                  pop,
   output logic                  rsp_valid,
   output ls3_pkg::word_type     rsp_sol_0,
   output ls3_pkg::word_type     rsp_sol_1,
   output ls3_pkg::word_type     rsp_sol_2,
   output logic [1:0]            rsp_solve_status
);
   import ls3_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PIV   = 6'b000010,
      S_DIV   = 6'b000100,
      S_UPD   = 6'b001000,
      S_BACK  = 6'b010000,
      S_BDIV  = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   word_type [2:0][3:0] m_ff, m_in;
   word_type [2:0] x_ff, x_in;
   word_type f_ff, f_in, acc_ff, acc_in;
   logic [1:0] col_ff, col_in, r_ff, r_in, j_ff, j_in;
   logic sat_ff, sat_in, dgo, ddone, dsat;
   word_type dnum, dden, dq;
   logic out_v_ff, out_v_in;
   word_type [2:0] out_x_ff, out_x_in;
   logic [1:0] out_s_ff, out_s_in;
   logic dwait_ff, dwait_in;
   logic [1:0] p;
   logic [DW:0] pm, t1, t2;
   word_type [3:0] tmp;

   ls3_div u_div (.clock(clock), .reset(reset), .start(dgo), .num(dnum), .den(dden),
                  .done(ddone), .quo(dq), .sat(dsat));

   always_comb begin
      st_in = st_ff; m_in = m_ff; x_in = x_ff; f_in = f_ff; acc_in = acc_ff;
      col_in = col_ff; r_in = r_ff; j_in = j_ff; sat_in = sat_ff; dwait_in = dwait_ff;
      out_v_in = 1'b0; out_x_in = out_x_ff; out_s_in = out_s_ff;
      pop = 1'b0; dgo = 1'b0; dnum = '0; dden = '0;
      p = col_ff; pm = '0; t1 = '0; t2 = '0; tmp = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (avail) begin
               pop = 1'b1; m_in = job.m; col_in = '0; sat_in = 1'b0;
               st_in = S_PIV;
            end
         end
         S_PIV: begin
            pm = mag(m_ff[col_ff][col_ff]);
            for (int k = 1; k < 3; k++) begin
               if (2'(k) > col_ff && mag(m_ff[k][col_ff]) > pm) begin
                  p = 2'(k); pm = mag(m_ff[k][col_ff]);
               end
            end
            tmp = m_ff[col_ff];
            m_in[col_ff] = m_ff[p];
            m_in[p] = tmp;
            if (pm < {2'b00, thresh}) begin
               out_v_in = 1'b1; out_x_in = '0; out_s_in = ST_SING;
               st_in = S_IDLE;
            end else if (col_ff == 2'd2) begin
               r_in = 2'd2; j_in = 2'd3; acc_in = m_in[2][3];
               st_in = S_BACK;
            end else begin
               r_in = col_ff + 2'd1; dwait_in = 1'b0; st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!dwait_ff) begin
               dgo = 1'b1; dnum = m_ff[r_ff][col_ff]; dden = m_ff[col_ff][col_ff];
               dwait_in = 1'b1;
            end else if (ddone) begin
               f_in = dq; sat_in = sat_ff | dsat; dwait_in = 1'b0;
               m_in[r_ff][col_ff] = '0; j_in = col_ff + 2'd1; st_in = S_UPD;
            end
         end
         S_UPD: begin
            t1 = fmul(f_ff, m_ff[col_ff][j_ff]);
            t2 = fsub(m_ff[r_ff][j_ff], t1[DW-1:0]);
            m_in[r_ff][j_ff] = t2[DW-1:0];
            sat_in = sat_ff | t1[DW] | t2[DW];
            if (j_ff == 2'd3) begin
               if (r_ff == 2'd2) begin
                  col_in = col_ff + 2'd1; st_in = S_PIV;
               end else begin
                  r_in = r_ff + 2'd1; st_in = S_DIV;
               end
            end else j_in = j_ff + 2'd1;
         end
         S_BACK: begin
            // j walks from r+1 up to 2; j of 3 means no terms left.
            if (j_ff != 2'd3) begin
               t1 = fmul(m_ff[r_ff][j_ff], x_ff[j_ff]);
               t2 = fsub(acc_ff, t1[DW-1:0]);
               acc_in = t2[DW-1:0];
               sat_in = sat_ff | t1[DW] | t2[DW];
               j_in = j_ff + 2'd1;
            end else begin
               dwait_in = 1'b0; st_in = S_BDIV;
            end
         end
         S_BDIV: begin
            if (!dwait_ff) begin
               dgo = 1'b1; dnum = acc_ff; dden = m_ff[r_ff][r_ff]; dwait_in = 1'b1;
            end else if (ddone) begin
               dwait_in = 1'b0;
               x_in[r_ff] = dq;
               sat_in = sat_ff | dsat;
               if (r_ff == 2'd0) begin
                  out_v_in = 1'b1;
                  out_x_in = {x_in[2], x_in[1], dq};
                  out_s_in = (sat_ff | dsat) ? ST_SAT : ST_OK;
                  st_in = S_IDLE;
               end else begin
                  r_in = r_ff - 2'd1; acc_in = m_ff[r_ff - 2'd1][3];
                  j_in = r_ff; st_in = S_BACK;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; out_v_ff <= 1'b0; dwait_ff <= 1'b0;
      end else begin
         st_ff <= st_in; out_v_ff <= out_v_in; dwait_ff <= dwait_in;
      end
      m_ff <= m_in; x_ff <= x_in; f_ff <= f_in; acc_ff <= acc_in;
      col_ff <= col_in; r_ff <= r_in; j_ff <= j_in; sat_ff <= sat_in;
      out_x_ff <= out_x_in; out_s_ff <= out_s_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_sol_0 = out_x_ff[0];
   assign rsp_sol_1 = out_x_ff[1];
   assign rsp_sol_2 = out_x_ff[2];
   assign rsp_solve_status = out_s_ff;
endmodule
`default_nettype wire

FILE: sv/linear_solve_3x3_pivoting.sv
`default_nettype none
// ---------------------------------------------------------------------------
// linear_solve_3x3_pivoting: 3x3 solver with partial pivoting, Q16.16
// Front queue holds accepted systems, the core eliminates and back-solves.
// ---------------------------------------------------------------------------
// channel   handshake        payload
// req       start / busy     req_a_r*c*, req_rhs_*
// rsp       rsp_valid strobe rsp_sol_*, rsp_solve_status
// csr       csr_we           csr_wdata (pivot threshold)
//
// A solvable system holds the core through six divisions in the bit-serial
// divider, each of 49 quotient steps plus a start and a hand-off step, and
// through the pop, pivot, update and back-substitution steps around them.
// A singular system leaves the core at the pivot check that finds it. The
// result strobe is registered from the core's final state; the core takes
// the next queued system only once it has returned to idle.
// Up to two systems wait in the front queue; busy is high while it is full.
// The receiver cannot stall. Reset is synchronous and sets the threshold to 1 LSB (2^-16).
// ---------------------------------------------------------------------------
module linear_solve_3x3_pivoting (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ls3_pkg::word_type req_a_r0c0,
   input  wire ls3_pkg::word_type req_a_r0c1,
   input  wire ls3_pkg::word_type req_a_r0c2,
   input  wire ls3_pkg::word_type req_a_r1c0,
   input  wire ls3_pkg::word_type req_a_r1c1,
   input  wire ls3_pkg::word_type req_a_r1c2,
   input  wire ls3_pkg::word_type req_a_r2c0,
   input  wire ls3_pkg::word_type req_a_r2c1,
   input  wire ls3_pkg::word_type req_a_r2c2,
   input  wire ls3_pkg::word_type req_rhs_0,
   input  wire ls3_pkg::word_type req_rhs_1,
   input  wire ls3_pkg::word_type req_rhs_2,
   input  wire logic              csr_we,
   input  wire logic [30:0]       csr_wdata,
   output logic                   rsp_valid,
   output ls3_pkg::word_type      rsp_sol_0,
   output ls3_pkg::word_type      rsp_sol_1,
   output ls3_pkg::word_type      rsp_sol_2,
   output logic [1:0]             rsp_solve_status
);
   import ls3_pkg::*;
   logic [30:0] thr_ff;
   job_type     pj, hj;
   logic        full, avail, pop, push;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 31'd1;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   assign pj.m = {req_rhs_2, req_a_r2c2, req_a_r2c1, req_a_r2c0,
                  req_rhs_1, req_a_r1c2, req_a_r1c1, req_a_r1c0,
                  req_rhs_0, req_a_r0c2, req_a_r0c1, req_a_r0c0};
   assign busy = full;
   assign push = start && !full;

   ls3_front u_front (.clock(clock), .reset(reset), .push(push), .push_job(pj),
                      .full(full), .pop(pop), .avail(avail), .head(hj));

   ls3_core u_core (.clock(clock), .reset(reset), .thresh(thr_ff), .avail(avail),
                    .job(hj), .pop(pop), .rsp_valid(rsp_valid), .rsp_sol_0(rsp_sol_0),
                    .rsp_sol_1(rsp_sol_1), .rsp_sol_2(rsp_sol_2),
                    .rsp_solve_status(rsp_solve_status));

   // Status never takes the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_solve_status != 2'd3) else $error("bad status");
   // A singular result carries a zero solution.
   a_sing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_solve_status == ST_SING) |->
      (rsp_sol_0 == '0 && rsp_sol_1 == '0 && rsp_sol_2 == '0)) else $error("sing nonzero");
   // A pop only happens when the queue holds something.
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> avail) else $error("pop empty");
endmodule
`default_nettype wire
